FILE: design/lbls_pkg.sv
// shared constants, table and cosine helper for the breathing led sequencer
// no dependencies; imported by lbls_div, lbls_wave, the top level and the testbench
package lbls_pkg;

    localparam int PHASE_BITS_DEF = 10;

    localparam int CNT_W   = 20;
    localparam int INIT_W  = 16;
    localparam int STEP_W  = 12;
    localparam int PEAK_W  = 7;
    localparam int LEVEL_W = 8;
    localparam int ANGLE_W = 12;
    localparam int OMC_W   = 17;
    localparam int ACC_W   = 23;
    localparam int IDX_W   = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_RUN_LENGTH  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_INIT_PERIOD = 8'd1;
    localparam logic [IDX_W-1:0] CFG_PERIOD_STEP = 8'd2;
    localparam logic [IDX_W-1:0] CFG_PEAK_LEVEL  = 8'd3;

    localparam logic [CNT_W-1:0]  RUN_LENGTH_RST  = 20'd480000;
    localparam logic [INIT_W-1:0] INIT_PERIOD_RST = 16'd8000;
    localparam logic [STEP_W-1:0] PERIOD_STEP_RST = 12'd100;
    localparam logic [PEAK_W-1:0] PEAK_LEVEL_RST  = 7'd100;

    // cos(k*pi/32) for k = 0..16, 1.0 = 32768
    localparam logic [15:0] QUARTER_COS [17] = '{
        16'd32768, 16'd32610, 16'd32138, 16'd31357, 16'd30274, 16'd28899,
        16'd27246, 16'd25330, 16'd23170, 16'd20788, 16'd18205, 16'd15447,
        16'd12540, 16'd9512,  16'd6393,  16'd3212,  16'd0
    };

    // quarter-wave cosine, x in 0..1024 (1024 = pi/2), linear interpolation
    function automatic logic [15:0] quarter_lookup(input logic [10:0] x);
        logic [4:0]  idx;
        logic [5:0]  frac;
        logic [15:0] diff;
        logic [17:0] drop;
        idx  = x[10:6];
        frac = x[5:0];
        if (idx >= 5'd16) begin
            quarter_lookup = QUARTER_COS[16];
        end else begin
            diff = QUARTER_COS[idx] - QUARTER_COS[idx + 5'd1];
            drop = (18'(diff[11:0]) * 18'(frac) + 18'd32) >> 6;
            quarter_lookup = QUARTER_COS[idx] - drop[15:0];
        end
    endfunction

    // 32768*(1-cos) for a 12-bit full-circle angle, 0..65536
    function automatic logic [OMC_W-1:0] one_minus_cos(input logic [ANGLE_W-1:0] a);
        logic [1:0]  quad;
        logic [10:0] r;
        logic [10:0] rr;
        quad = a[11:10];
        r    = {1'b0, a[9:0]};
        rr   = 11'd1024 - r;
        case (quad)
            2'd0: begin
                one_minus_cos = 17'd32768 - 17'(quarter_lookup(r));
            end
            2'd1: begin
                one_minus_cos = 17'd32768 + 17'(quarter_lookup(rr));
            end
            2'd2: begin
                one_minus_cos = 17'd32768 + 17'(quarter_lookup(r));
            end
            default: begin
                one_minus_cos = 17'd32768 - 17'(quarter_lookup(rr));
            end
        endcase
    endfunction

endpackage

FILE: design/lbls_div.sv
// restoring radix-2 divider producing the pulse phase, one quotient bit a cycle
// depends on lbls_pkg
module lbls_div
    import lbls_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CNT_W-1:0]      i_num,
    input  logic [CNT_W-1:0]      i_den,
    output logic                  o_done,
    output logic [PHASE_BITS-1:0] o_phase
);

    localparam int STEP_CW = $clog2(PHASE_BITS + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [STEP_CW-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic [CNT_W-1:0]      r_den, n_den;
    logic [PHASE_BITS-1:0] r_quo, n_quo;
    logic                  r_zero, n_zero;
    logic [CNT_W:0]        w_shift;
    logic                  w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_zero = r_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_CW'(PHASE_BITS);
            n_rem  = i_num;
            n_den  = i_den;
            n_quo  = '0;
            // full turn or empty period both give phase zero
            n_zero = (i_num >= i_den) || (i_den == '0);
        end else if (r_busy) begin
            n_rem = w_ge ? CNT_W'(w_shift - {1'b0, r_den}) : w_shift[CNT_W-1:0];
            n_quo = {r_quo[PHASE_BITS-2:0], w_ge};
            n_cnt = r_cnt - STEP_CW'(1);
            if (r_cnt == STEP_CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_zero <= n_zero;
    end

    assign o_done  = r_done;
    assign o_phase = r_zero ? '0 : r_quo;

endmodule

FILE: design/lbls_wave.sv
// raised-cosine shaper: table lookup, then bit-serial peak multiply msb first
// depends on lbls_pkg
module lbls_wave
    import lbls_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [PHASE_BITS-1:0] i_phase,
    input  logic [PEAK_W-1:0]     i_peak,
    output logic                  o_done,
    output logic [LEVEL_W-1:0]    o_level
);

    localparam int SEQ_W = $clog2(PEAK_W + 2);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [SEQ_W-1:0]     r_cnt, n_cnt;
    logic [ANGLE_W-1:0]   r_angle, n_angle;
    logic [PEAK_W-1:0]    r_peak, n_peak;
    logic [OMC_W-1:0]     r_omc, n_omc;
    logic [ACC_W-1:0]     r_acc, n_acc;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_angle = r_angle;
        n_peak  = r_peak;
        n_omc   = r_omc;
        n_acc   = r_acc;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = SEQ_W'(PEAK_W + 1);
            n_angle = ANGLE_W'(i_phase) << (ANGLE_W - PHASE_BITS);
            n_peak  = i_peak;
            n_acc   = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt - SEQ_W'(1);
            if (r_cnt == SEQ_W'(PEAK_W + 1)) begin
                n_omc = one_minus_cos(r_angle);
            end else begin
                // shift-add, one peak bit per cycle
                n_acc  = {r_acc[ACC_W-2:0], 1'b0} + (r_peak[PEAK_W-1] ? ACC_W'(r_omc) : '0);
                n_peak = {r_peak[PEAK_W-2:0], 1'b0};
                if (r_cnt == SEQ_W'(1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_angle <= n_angle;
        r_peak  <= n_peak;
        r_omc   <= n_omc;
        r_acc   <= n_acc;
    end

    assign o_done  = r_done;
    assign o_level = r_acc[ACC_W-1:ACC_W-LEVEL_W];

endmodule

FILE: design/lengthening_breathing_led_sequencer.sv
// top level of the lengthening breathing led sequencer: session control,
// config registers and output register; depends on lbls_pkg, lbls_div, lbls_wave
//
// channel | direction | handshake                      | payload
// --------+-----------+--------------------------------+----------------------------------
// s_axis  | in        | s_axis_tvalid / s_axis_tready  | tdata: presence (bit 0)
// m_axis  | out       | m_axis_tvalid / m_axis_tready  | tdata: level; tuser: active
// cfg     | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// idle ticks, session start and pulse end ticks: result is registered in the cycle
// after the word is taken; breathing ticks go through the restoring divider
// (one quotient bit a cycle) and then the serial peak multiply
// reset is synchronous, active low, and returns the block idle with default config
// a stalled output holds its word; a new input word is taken only in the idle state
// while the output register is free or being emptied in the same cycle
module lengthening_breathing_led_sequencer
    import lbls_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [0] presence, [7:1] zero fill
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] level
    output logic [0:0]         m_axis_tuser,   // [0] active
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_PUT  = 2'd2;

    // configuration
    logic [CNT_W-1:0]   r_run_length;
    logic [INIT_W-1:0]  r_init_period;
    logic [STEP_W-1:0]  r_period_step;
    logic [PEAK_W-1:0]  r_peak;

    // session state
    logic [1:0]         r_state, n_state;
    logic               r_session, n_session;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [CNT_W-1:0]   r_pulse, n_pulse;
    logic [CNT_W-1:0]   r_period, n_period;
    logic [LEVEL_W-1:0] r_last, n_last;
    logic [LEVEL_W-1:0] r_hold, n_hold;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [LEVEL_W-1:0] r_out_level, n_out_level;
    logic               r_out_active, n_out_active;

    logic               w_out_free;
    logic               w_accept;
    logic [CNT_W-1:0]   w_run_inc;
    logic [CNT_W-1:0]   w_pulse_inc;
    logic [CNT_W:0]     w_grown;
    logic               w_div_start;
    logic               w_div_done;
    logic [PHASE_BITS-1:0] w_phase;
    logic               w_wave_done;
    logic [LEVEL_W-1:0] w_level;

    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // saturating counters and period growth
    assign w_run_inc   = (r_run == CNT_MAX) ? r_run : r_run + CNT_W'(1);
    assign w_pulse_inc = (r_pulse == CNT_MAX) ? r_pulse : r_pulse + CNT_W'(1);
    assign w_grown     = {1'b0, r_period} + (CNT_W + 1)'(r_period_step);

    always_comb begin
        n_state      = r_state;
        n_session    = r_session;
        n_run        = r_run;
        n_pulse      = r_pulse;
        n_period     = r_period;
        n_last       = r_last;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_level  = r_out_level;
        n_out_active = r_out_active;
        w_div_start  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!r_session) begin
                        // idle tick, maybe a session start
                        if (s_axis_tdata[0]) begin
                            n_session = 1'b1;
                            n_run     = '0;
                            n_pulse   = '0;
                            n_period  = CNT_W'(r_init_period);
                        end
                        n_last       = '0;
                        n_out_valid  = 1'b1;
                        n_out_level  = '0;
                        n_out_active = s_axis_tdata[0];
                    end else begin
                        n_run   = w_run_inc;
                        n_pulse = w_pulse_inc;
                        if (w_pulse_inc > r_period) begin
                            // pulse end: grow the period, then restart or stop
                            n_period = w_grown[CNT_W] ? CNT_MAX : w_grown[CNT_W-1:0];
                            n_out_valid = 1'b1;
                            if (w_run_inc > r_run_length) begin
                                n_session    = 1'b0;
                                n_last       = '0;
                                n_out_level  = '0;
                                n_out_active = 1'b0;
                            end else begin
                                n_pulse      = '0;
                                n_out_level  = r_last;
                                n_out_active = 1'b1;
                            end
                        end else begin
                            // breathing tick: phase divide then cosine shaping
                            w_div_start = 1'b1;
                            n_state     = ST_BUSY;
                        end
                    end
                end
            end
            ST_BUSY: begin
                if (w_wave_done) begin
                    n_hold  = w_level;
                    n_last  = w_level;
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_level  = r_hold;
                    n_out_active = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_session   <= 1'b0;
            r_run       <= '0;
            r_pulse     <= '0;
            r_period    <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_session   <= n_session;
            r_run       <= n_run;
            r_pulse     <= n_pulse;
            r_period    <= n_period;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold       <= n_hold;
        r_out_level  <= n_out_level;
        r_out_active <= n_out_active;
    end

    // config writes, out-of-range indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_length  <= RUN_LENGTH_RST;
            r_init_period <= INIT_PERIOD_RST;
            r_period_step <= PERIOD_STEP_RST;
            r_peak        <= PEAK_LEVEL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RUN_LENGTH:  r_run_length  <= i_cfg_data;
                CFG_INIT_PERIOD: r_init_period <= i_cfg_data[INIT_W-1:0];
                CFG_PERIOD_STEP: r_period_step <= i_cfg_data[STEP_W-1:0];
                CFG_PEAK_LEVEL:  r_peak        <= i_cfg_data[PEAK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lbls_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_pulse_inc),
        .i_den   (r_period),
        .o_done  (w_div_done),
        .o_phase (w_phase)
    );

    lbls_wave #(
        .PHASE_BITS (PHASE_BITS)
    ) u_wave (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_done),
        .i_phase (w_phase),
        .i_peak  (r_peak),
        .o_done  (w_wave_done),
        .o_level (w_level)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_level;
    assign m_axis_tuser  = r_out_active;

endmodule

FILE: test/testbench.sv
// self-checking testbench for lengthening_breathing_led_sequencer: directed plan, then
// random sessions; each word is checked against its typed plan value or a tick predictor
// depends on lbls_pkg (widths, register indexes, phase width) and the top level rtl
module testbench;
    import lbls_pkg::*;

    localparam int PB             = PHASE_BITS_DEF;
    localparam int SETTLE_CYCLES  = 2 * (PB + 11) + 8;  // one breathing tick, with margin
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 1200;
    localparam int PRINT_CAP      = 50;

    localparam logic [CNT_W-1:0] ONES      = '1;
    localparam logic [CNT_W-1:0] CNT_TOP   = '1;
    localparam logic [IDX_W-1:0] CFG_NOREG = 8'd4;  // first index past the register map

    // cos(k*pi/32), k = 0..16, 1.0 = 32768
    localparam int unsigned COS_STEPS [17] = '{
        32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
        20788, 18205, 15447, 12540, 9512, 6393, 3212, 0
    };

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] val;
        logic             pres;
        logic             typed;   // expected word given below instead of predicted
        logic [7:0]       lvl;
        logic             act;
    } t_plan_row;

    typedef struct packed {
        logic       typed;
        logic [7:0] lvl;
        logic       act;
    } t_hint;

    typedef struct packed {
        logic [7:0] lvl;
        logic       act;
    } t_led_word;

    // directed plan: short sessions, pulse ends, zero period, masking and extremes
    localparam t_plan_row PLAN [42] = '{
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, 8'd0, 1'b0},                  // idle after reset
        '{ROW_CFG, CFG_PEAK_LEVEL, 20'd127, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_INIT_PERIOD, 20'd2, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_PERIOD_STEP, 20'd1, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_RUN_LENGTH, 20'd6, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b1, 8'd0, 1'b1},                  // session start
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, 8'd254, 1'b1},                // half turn, full peak
        '{ROW_TICK, '0, '0, 1'b1, 1'b0, 8'd0, 1'b0},                  // full turn wraps
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0},                  // pulse end
        '{ROW_TICK, '0, '0, 1'b1, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, 8'd0, 1'b0},                  // session end
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, 8'd0, 1'b0},
        '{ROW_CFG, CFG_INIT_PERIOD, 20'd0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_PERIOD_STEP, 20'd0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_RUN_LENGTH, 20'd2, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_NOREG, ONES, 1'b0, 1'b0, 8'd0, 1'b0},          // must be ignored
        '{ROW_TICK, '0, '0, 1'b1, 1'b1, 8'd0, 1'b1},                  // start, zero period
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, 8'd0, 1'b0},
        '{ROW_CFG, CFG_RUN_LENGTH, ONES, 1'b0, 1'b0, 8'd0, 1'b0},     // never-ending run
        '{ROW_CFG, CFG_INIT_PERIOD, 20'd3, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_PERIOD_STEP, 20'd2, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_PEAK_LEVEL, 20'd0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b1, 8'd0, 1'b1},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_PERIOD_STEP, ONES, 1'b0, 1'b0, 8'd0, 1'b0},    // all-ones, masked
        '{ROW_CFG, CFG_INIT_PERIOD, ONES, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_PEAK_LEVEL, ONES, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_PERIOD_STEP, 20'd1, 1'b0, 1'b0, 8'd0, 1'b0},   // back to short pulses
        '{ROW_CFG, CFG_INIT_PERIOD, 20'd5, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, CFG_RUN_LENGTH, 20'd0, 1'b0, 1'b0, 8'd0, 1'b0},    // ends at next pulse end
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 1'b0}
    };

    // dut ports, inputs known from time zero
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = 8'd0;   // [0] presence, [7:1] zero fill
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;           // [7:0] level
    logic [0:0]       m_axis_tuser;           // [0] active
    logic             i_cfg_valid   = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index   = '0;
    logic [CNT_W-1:0] i_cfg_data    = '0;

    // predictor copy of the registers
    logic [CNT_W-1:0]  run_len     = 20'd480000;
    logic [INIT_W-1:0] init_period = 16'd8000;
    logic [STEP_W-1:0] step_ms     = 12'd100;
    logic [PEAK_W-1:0] peak        = 7'd100;

    // predictor copy of the session state
    logic              sess_on    = 1'b0;
    logic [CNT_W-1:0]  run_ms     = '0;
    logic [CNT_W-1:0]  pulse_ms   = '0;
    logic [CNT_W-1:0]  period_ms  = '0;
    logic [7:0]        held_level = '0;

    t_led_word   expected_q [$];
    t_hint       hint_q [$];
    int          mismatches    = 0;
    int          words_checked = 0;
    int          items_sent    = 0;
    int          quiet_cycles  = 0;
    bit          calm          = 1'b0;   // no idling on either side while set
    int          rx_hold       = 0;

    lengthening_breathing_led_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // cos over a quarter turn, x in 0..1024 (1024 = pi/2), interpolated between steps
    function automatic int unsigned quarter_cos_of(input int unsigned x);
        int unsigned seg;
        int unsigned frac;
        seg  = (x >> 6) & 31;
        frac = x & 63;
        if (seg >= 16)
            return COS_STEPS[16];
        return COS_STEPS[seg] - (((COS_STEPS[seg] - COS_STEPS[seg + 1]) * frac + 32) >> 6);
    endfunction

    // 32768*(1-cos) for a 12-bit full-circle angle
    function automatic int unsigned lift_of(input int unsigned angle);
        int unsigned rem;
        rem = angle & 1023;
        case ((angle >> 10) & 3)
            0: return 32768 - quarter_cos_of(rem);
            1: return 32768 + quarter_cos_of(1024 - rem);
            2: return 32768 + quarter_cos_of(rem);
            default: return 32768 - quarter_cos_of(1024 - rem);
        endcase
    endfunction

    // one millisecond tick of the sequencer: updates the state, returns the led word
    function automatic t_led_word next_led_word(input logic presence);
        t_led_word       w;
        logic [CNT_W:0]  grown;
        longint unsigned scaled;
        int unsigned     phase;
        int unsigned     raw;
        w = '0;
        if (!sess_on) begin
            if (presence) begin
                sess_on   = 1'b1;
                run_ms    = '0;
                pulse_ms  = '0;
                period_ms = CNT_W'(init_period);
            end
            held_level = 8'd0;
        end else begin
            // both counters stop at the top of their range
            run_ms   = (run_ms == CNT_TOP) ? run_ms : run_ms + 1'b1;
            pulse_ms = (pulse_ms == CNT_TOP) ? pulse_ms : pulse_ms + 1'b1;
            if (pulse_ms > period_ms) begin
                grown     = {1'b0, period_ms} + (CNT_W + 1)'(step_ms);
                period_ms = grown[CNT_W] ? CNT_TOP : grown[CNT_W-1:0];
                if (run_ms > run_len) begin
                    sess_on    = 1'b0;
                    held_level = 8'd0;
                end else begin
                    // pulse restarts, level holds for this tick
                    pulse_ms = '0;
                    w.lvl    = held_level;
                end
            end else begin
                phase = 0;
                if (period_ms != '0) begin
                    scaled = 64'(pulse_ms) << PB;
                    phase  = 32'(scaled / 64'(period_ms));
                end
                phase      = phase & ((1 << PB) - 1);   // a full turn wraps to zero
                raw        = (32'(peak) * lift_of((phase << (12 - PB)) & 4095)) >> 15;
                w.lvl      = (raw > 255) ? 8'd255 : raw[7:0];
                held_level = w.lvl;
            end
        end
        w.act = sess_on;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch on word %0d: %s", words_checked, msg);
        mismatches++;
    endtask

    // mostly short gaps, a few long ones, none while calm
    function automatic int pause_len();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sends one tick word; valid stays high on return so back-to-back words need no dip
    task automatic push_tick(input logic pres, input logic typed, input logic [7:0] lvl,
                             input logic act);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hint_q.push_back('{typed, lvl, act});
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pres};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // register write; valid is left high so the caller lowers it after the last one
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RUN_LENGTH:  run_len     = val;
            CFG_INIT_PERIOD: init_period = val[INIT_W-1:0];
            CFG_PERIOD_STEP: step_ms     = val[STEP_W-1:0];
            CFG_PEAK_LEVEL:  peak        = val[PEAK_W-1:0];
            default: ;
        endcase
    endtask

    // stop sending, wait for every expected word, then let the block settle
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sink side: random stalls, long ones now and then
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            rx_hold = pause_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watches both word channels: predicts on input words, checks output words
    always @(posedge i_clk) begin : monitor
        t_hint     hint;
        t_led_word guess;
        t_led_word want;
        logic      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                hint  = '0;
                if (hint_q.size() != 0)
                    hint = hint_q.pop_front();
                guess = next_led_word(s_axis_tdata[0]);
                expected_q.push_back(hint.typed ? t_led_word'{hint.lvl, hint.act} : guess);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("word level %0d active %0b with none pending",
                                              m_axis_tdata, m_axis_tuser[0]));
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata !== want.lvl)
                        report_mismatch($sformatf("level %0d, want %0d",
                                                  m_axis_tdata, want.lvl));
                    if (m_axis_tuser[0] !== want.act)
                        report_mismatch($sformatf("active %0b, want %0b",
                                                  m_axis_tuser[0], want.act));
                end
                words_checked++;
            end
            if (i_cfg_valid && o_cfg_ready)
                moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // watchdog on cycles with no accepted word on any channel
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int        burst;
        int        odds;
        int        roll;
        bit        cfg_open;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan; register writes only after the block has drained
        cfg_open = 1'b1;
        foreach (PLAN[k]) begin
            if (PLAN[k].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    wait_quiet();
                    cfg_open = 1'b1;
                end
                write_reg(PLAN[k].idx, PLAN[k].val);
            end else begin
                if (cfg_open) begin
                    i_cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                push_tick(PLAN[k].pres, PLAN[k].typed, PLAN[k].lvl, PLAN[k].act);
            end
        end

        // random phases: drain, new settings, then a burst of ticks
        while (items_sent < ITEM_TARGET) begin
            wait_quiet();
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1) == 1) begin
                roll = $urandom_range(0, 19);
                write_reg(CFG_RUN_LENGTH,
                          (roll < 14) ? CNT_W'($urandom_range(0, 200)) :
                          (roll < 17) ? CNT_W'($urandom_range(1000, 5000)) :
                          (roll < 19) ? ONES : CNT_W'($urandom()));
            end
            if ($urandom_range(0, 1) == 1) begin
                roll = $urandom_range(0, 19);
                write_reg(CFG_INIT_PERIOD,
                          (roll < 15) ? CNT_W'($urandom_range(1, 40)) :
                          (roll < 17) ? CNT_W'(0) : CNT_W'($urandom_range(41, 600)));
            end
            if ($urandom_range(0, 1) == 1) begin
                roll = $urandom_range(0, 19);
                write_reg(CFG_PERIOD_STEP,
                          (roll < 14) ? CNT_W'($urandom_range(0, 6)) :
                          (roll < 18) ? CNT_W'($urandom_range(7, 40)) : CNT_W'(0));
            end
            if ($urandom_range(0, 1) == 1) begin
                roll = $urandom_range(0, 19);
                write_reg(CFG_PEAK_LEVEL,
                          (roll < 16) ? CNT_W'($urandom_range(0, 127)) :
                          (roll < 18) ? CNT_W'(0) : ONES);
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_NOREG, CNT_W'($urandom()));
            i_cfg_valid <= 1'b0;

            // presence density differs per phase: sparse sensors and busy ones
            burst = $urandom_range(30, 120);
            odds  = $urandom_range(1, 9);
            repeat (burst) push_tick($urandom_range(0, 9) < odds, 1'b0, 8'd0, 1'b0);
        end

        wait_quiet();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
